// File: src/botd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// botd_pkg
// Types and constants shared by the BER OID TLV decoder files.
// ----------------------------------------------------------------------------
package botd_pkg;

	localparam logic [7:0] OID_TAG   = 8'h06;
	localparam logic [7:0] SUB_MASK  = 8'h7F;
	localparam logic [7:0] CONT_BIT  = 8'h80;
	localparam logic [7:0] MIN_CAP   = 8'd2;
	localparam logic [2:0] MAX_LEN_BYTES = 3'd4;
	localparam logic [31:0] ARC_DIV  = 32'd40;

	typedef enum logic [1:0] {
		KIND_ARC  = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_NO_DATA  = 4'd1;
	localparam logic [3:0] ERR_HDR_CUT  = 4'd2;
	localparam logic [3:0] ERR_LEN_FORM = 4'd3;
	localparam logic [3:0] ERR_LEN_LONG = 4'd4;
	localparam logic [3:0] ERR_TAG      = 4'd5;
	localparam logic [3:0] ERR_EMPTY    = 4'd6;
	localparam logic [3:0] ERR_CAP      = 4'd7;
	localparam logic [3:0] ERR_TOO_MANY = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_LEN0 = 4'b0010,
		PH_LENX = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  byte_req;
		logic        start_req;
		logic [15:0] bytes_left;
		logic        upstream_ok;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] arc;
		logic [7:0]  arc_position;
		logic [3:0]  error_code;
	} res_t;

	// up to three results caused by one byte
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [2:0]     res;
	} bundle_t;

endpackage

// File: src/botd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// botd_if
// Valid/ready channels for message bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface botd_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_req;
	logic        start_req;
	logic [15:0] bytes_left;
	logic        upstream_ok;

	modport source (output valid, byte_req, start_req, bytes_left, upstream_ok,
		input ready);
	modport sink (input valid, byte_req, start_req, bytes_left, upstream_ok,
		output ready);
endinterface

interface botd_rsp_if;
	logic               valid;
	logic               ready;
	botd_pkg::kind_t    kind;
	logic [31:0]        arc;
	logic [7:0]         arc_position;
	logic [3:0]         error_code;

	modport source (output valid, kind, arc, arc_position, error_code,
		input ready);
	modport sink (input valid, kind, arc, arc_position, error_code,
		output ready);
endinterface

// File: src/botd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// botd_parse
// Parser state and per-byte result logic: header, length, subidentifiers.
// ----------------------------------------------------------------------------
module botd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  botd_pkg::req_t    item,
	input  logic [7:0]        cap,
	output botd_pkg::bundle_t bundle
);

	botd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  tag_q, tag_d;
	logic [2:0]  ltg_q, ltg_d;
	logic [31:0] decl_q, decl_d;
	logic [15:0] bufr_q, bufr_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  total_q, total_d;
	logic        first_q, first_d;

	logic [31:0] acc_n;
	logic [6:0]  lcnt;
	logic [1:0]  a0;
	logic [31:0] a0_sub;
	logic        failed;

	function automatic botd_pkg::res_t mk_res(botd_pkg::kind_t k, logic [31:0] v,
		logic [7:0] p, logic [3:0] e);
		botd_pkg::res_t r;
		r.kind         = k;
		r.arc          = v;
		r.arc_position = p;
		r.error_code   = e;
		return r;
	endfunction

	function automatic logic [3:0] hdr_check(logic [31:0] d, logic [15:0] b,
		logic [7:0] t, logic [7:0] c);
		logic [3:0] e;
		e = botd_pkg::ERR_NONE;
		if (d > {16'd0, b}) e = botd_pkg::ERR_LEN_LONG;
		else if (t != botd_pkg::OID_TAG) e = botd_pkg::ERR_TAG;
		else if (d == 32'd0) e = botd_pkg::ERR_EMPTY;
		else if (c < botd_pkg::MIN_CAP) e = botd_pkg::ERR_CAP;
		return e;
	endfunction

	assign acc_n = {acc_q[24:0], item.byte_req[6:0] & botd_pkg::SUB_MASK[6:0]};
	assign lcnt  = item.byte_req[6:0];

	// first subidentifier split: arc0 = min(v / 40, 2)
	always_comb begin
		if (acc_n >= (botd_pkg::ARC_DIV << 1)) begin
			a0     = 2'd2;
			a0_sub = botd_pkg::ARC_DIV << 1;
		end else if (acc_n >= botd_pkg::ARC_DIV) begin
			a0     = 2'd1;
			a0_sub = botd_pkg::ARC_DIV;
		end else begin
			a0     = 2'd0;
			a0_sub = 32'd0;
		end
	end

	always_comb begin
		logic [3:0] e;
		e       = botd_pkg::ERR_NONE;
		phase_d = phase_q;
		tag_d   = tag_q;
		ltg_d   = ltg_q;
		decl_d  = decl_q;
		bufr_d  = bufr_q;
		acc_d   = acc_q;
		total_d = total_q;
		first_d = first_q;
		failed  = 1'b0;
		bundle  = '0;

		if (item.start_req) begin
			phase_d = botd_pkg::PH_IDLE;
			if (!item.upstream_ok || item.bytes_left == 16'd0) begin
				bundle.cnt    = 2'd1;
				bundle.res[0] = mk_res(botd_pkg::KIND_ERR, 32'd0, 8'd0,
					botd_pkg::ERR_NO_DATA);
			end else begin
				tag_d  = item.byte_req;
				bufr_d = item.bytes_left - 16'd1;
				if (bufr_d == 16'd0) begin
					bundle.cnt    = 2'd1;
					bundle.res[0] = mk_res(botd_pkg::KIND_ERR, 32'd0, 8'd0,
						botd_pkg::ERR_HDR_CUT);
				end else begin
					ltg_d   = 3'd0;
					decl_d  = 32'd0;
					acc_d   = 32'd0;
					total_d = 8'd0;
					first_d = 1'b0;
					phase_d = botd_pkg::PH_LEN0;
				end
			end
		end else begin
			case (phase_q)
				botd_pkg::PH_LEN0: begin
					bufr_d = bufr_q - 16'd1;
					if ((item.byte_req & botd_pkg::CONT_BIT) == 8'd0) begin
						decl_d = {24'd0, item.byte_req};
						e = hdr_check(decl_d, bufr_d, tag_q, cap);
						phase_d = (e == botd_pkg::ERR_NONE) ? botd_pkg::PH_BODY
							: botd_pkg::PH_IDLE;
					end else if (lcnt == 7'd0 || lcnt > {4'd0, botd_pkg::MAX_LEN_BYTES}) begin
						e = botd_pkg::ERR_LEN_FORM;
						phase_d = botd_pkg::PH_IDLE;
					end else if ({9'd0, lcnt} > bufr_d) begin
						e = botd_pkg::ERR_HDR_CUT;
						phase_d = botd_pkg::PH_IDLE;
					end else begin
						ltg_d   = lcnt[2:0];
						decl_d  = 32'd0;
						phase_d = botd_pkg::PH_LENX;
					end
				end
				botd_pkg::PH_LENX: begin
					decl_d = {decl_q[23:0], item.byte_req};
					bufr_d = bufr_q - 16'd1;
					ltg_d  = ltg_q - 3'd1;
					if (ltg_d == 3'd0) begin
						e = hdr_check(decl_d, bufr_d, tag_q, cap);
						phase_d = (e == botd_pkg::ERR_NONE) ? botd_pkg::PH_BODY
							: botd_pkg::PH_IDLE;
					end
				end
				botd_pkg::PH_BODY: begin
					bufr_d = bufr_q - 16'd1;
					decl_d = decl_q - 32'd1;
					acc_d  = acc_n;
					if ((item.byte_req & botd_pkg::CONT_BIT) == 8'd0) begin
						acc_d = 32'd0;
						if (!first_q) begin
							bundle.res[0] = mk_res(botd_pkg::KIND_ARC, {30'd0, a0},
								8'd0, botd_pkg::ERR_NONE);
							bundle.res[1] = mk_res(botd_pkg::KIND_ARC, acc_n - a0_sub,
								8'd1, botd_pkg::ERR_NONE);
							bundle.cnt = 2'd2;
							total_d = 8'd2;
							first_d = 1'b1;
						end else if (total_q >= cap) begin
							failed  = 1'b1;
							e       = botd_pkg::ERR_TOO_MANY;
							phase_d = botd_pkg::PH_IDLE;
						end else begin
							bundle.res[0] = mk_res(botd_pkg::KIND_ARC, acc_n, total_q,
								botd_pkg::ERR_NONE);
							bundle.cnt = 2'd1;
							total_d = total_q + 8'd1;
						end
					end
					if (!failed && decl_d == 32'd0) begin
						bundle.res[bundle.cnt] = mk_res(botd_pkg::KIND_DONE, 32'd0,
							total_d, botd_pkg::ERR_NONE);
						bundle.cnt = bundle.cnt + 2'd1;
						phase_d = botd_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = botd_pkg::PH_IDLE;
				end
			endcase
			if (e != botd_pkg::ERR_NONE) begin
				bundle.cnt    = 2'd1;
				bundle.res[0] = mk_res(botd_pkg::KIND_ERR, 32'd0, 8'd0, e);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= botd_pkg::PH_IDLE;
			tag_q   <= 8'd0;
			ltg_q   <= 3'd0;
			decl_q  <= 32'd0;
			bufr_q  <= 16'd0;
			acc_q   <= 32'd0;
			total_q <= 8'd0;
			first_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			ltg_q   <= ltg_d;
			decl_q  <= decl_d;
			bufr_q  <= bufr_d;
			acc_q   <= acc_d;
			total_q <= total_d;
			first_q <= first_d;
		end
	end

	ap_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.start_req && phase_q == botd_pkg::PH_IDLE |-> bundle.cnt == 2'd0)
		else $error("byte outside a message produced a result");

	ap_body_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && bundle.cnt != 2'd0 && phase_d != botd_pkg::PH_IDLE
		|-> phase_q == botd_pkg::PH_BODY && bundle.res[0].kind == botd_pkg::KIND_ARC)
		else $error("result left the parser outside the idle state");

endmodule

// File: src/botd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// botd_emit
// Result register: holds one byte's results and hands them out in order.
// ----------------------------------------------------------------------------
module botd_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  botd_pkg::bundle_t bundle,
	output logic              free,
	botd_rsp_if.source        rsp
);

	botd_pkg::bundle_t bundle_s2;
	logic              valid_q;
	logic [1:0]        idx_q;
	logic              xfer;
	logic              last;
	botd_pkg::res_t    cur;

	assign xfer = rsp.valid && rsp.ready;
	assign last = (idx_q == bundle_s2.cnt - 2'd1);
	assign free = !valid_q || (xfer && last);
	assign cur  = bundle_s2.res[idx_q];

	assign rsp.valid        = valid_q;
	assign rsp.kind         = cur.kind;
	assign rsp.arc          = cur.arc;
	assign rsp.arc_position = cur.arc_position;
	assign rsp.error_code   = cur.error_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (xfer && last) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
		end
	end

	ap_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < bundle_s2.cnt)
		else $error("result index beyond the held results");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !rsp.ready |=> valid_q && $stable(idx_q))
		else $error("stalled result moved");

endmodule

// File: src/ber_oid_tlv_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_oid_tlv_decoder
// ASN.1 BER OBJECT IDENTIFIER decoder, one message byte per transfer.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   byte_req, start_req, bytes_left, upstream_ok
//   rsp      out  valid/ready   kind, arc, arc_position, error_code
//   cfg      in   cfg_we        cfg_wdata -> max_arcs
//
// A byte is taken into an input register, parsed from there and its results
// (none to three) land in the result register. One byte per cycle while each
// byte yields at most one result and rsp is ready; a byte with more results
// holds the result register until all are out. A stalled rsp holds the parser
// and input register if the held byte has results; req.ready drops only when
// both are occupied. Reset clears all parser state, sets max_arcs to MAX_ARCS.
// ----------------------------------------------------------------------------
module ber_oid_tlv_decoder #(
	parameter int MAX_ARCS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	botd_req_if.sink   req,
	botd_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [7:0]        max_arcs_q;
	logic [7:0]        cap;
	botd_pkg::req_t    item_s1;
	logic              valid_s1;
	logic              consume;
	logic              free;
	botd_pkg::bundle_t bundle;

	assign cap = (max_arcs_q < MAX_ARCS[7:0]) ? max_arcs_q : MAX_ARCS[7:0];

	assign consume   = valid_s1 && (bundle.cnt == 2'd0 || free);
	assign req.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arcs_q <= MAX_ARCS[7:0];
		end else if (cfg_we) begin
			max_arcs_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.byte_req    <= req.byte_req;
			item_s1.start_req   <= req.start_req;
			item_s1.bytes_left  <= req.bytes_left;
			item_s1.upstream_ok <= req.upstream_ok;
		end
	end

	botd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.item   (item_s1),
		.cap    (cap),
		.bundle (bundle)
	);

	botd_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume && bundle.cnt != 2'd0),
		.bundle (bundle),
		.free   (free),
		.rsp    (rsp)
	);

	ap_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("pending input byte lost");

endmodule

// File: verif/oid_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oid_result_checker
// Watches the byte and result channels of the BER OID TLV decoder. Every
// accepted byte is run through a cycle-free copy of the parser, which queues
// the arc, done and error results it should cause. Every accepted result is
// compared field by field with the oldest queued one. Writes to max_arcs are
// tracked from the configuration port.
// ----------------------------------------------------------------------------
module oid_result_checker #(
	parameter int MAX_ARCS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	botd_req_if        req,
	botd_rsp_if        rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         mismatches,
	output int         outstanding
);

	localparam logic [31:0] TOP_ARC_MAX = 32'd2;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'b0001,
		ST_LEN_FIRST = 4'b0010,
		ST_LEN_MORE  = 4'b0100,
		ST_CONTENT   = 4'b1000
	} parse_t;

	parse_t           parse_st;
	logic [7:0]       cap_reg;
	logic [7:0]       tag_byte;
	logic [2:0]       len_bytes_left;
	logic [31:0]      content_left;
	logic [15:0]      buf_left;
	logic [31:0]      subid_acc;
	logic [7:0]       arc_count;
	logic             split_done;
	botd_pkg::res_t   pending_results[$];

	function automatic logic [7:0] eff_cap();
		return (cap_reg < MAX_ARCS) ? cap_reg : 8'(MAX_ARCS);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t oid check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic expect_result(input botd_pkg::kind_t k, input logic [31:0] a,
			input logic [7:0] p, input logic [3:0] e);
		botd_pkg::res_t r;
		r.kind = k;
		r.arc = a;
		r.arc_position = p;
		r.error_code = e;
		pending_results.push_back(r);
	endtask

	task automatic expect_error(input logic [3:0] e);
		expect_result(botd_pkg::KIND_ERR, 32'd0, 8'd0, e);
		parse_st = ST_IDLE;
	endtask

	task automatic close_header();
		if (content_left > 32'(buf_left)) expect_error(botd_pkg::ERR_LEN_LONG);
		else if (tag_byte != botd_pkg::OID_TAG) expect_error(botd_pkg::ERR_TAG);
		else if (content_left == 32'd0) expect_error(botd_pkg::ERR_EMPTY);
		else if (eff_cap() < botd_pkg::MIN_CAP) expect_error(botd_pkg::ERR_CAP);
		else parse_st = ST_CONTENT;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic st, input logic [15:0] left,
			input logic ok);
		logic [31:0] top_arc;
		logic [7:0]  nlen;
		if (st) begin
			parse_st = ST_IDLE;
			if (!ok || left == 16'd0) begin
				expect_error(botd_pkg::ERR_NO_DATA);
				return;
			end
			tag_byte = b;
			buf_left = left - 16'd1;
			if (buf_left == 16'd0) begin
				expect_error(botd_pkg::ERR_HDR_CUT);
				return;
			end
			len_bytes_left = '0;
			content_left = '0;
			subid_acc = '0;
			arc_count = '0;
			split_done = 1'b0;
			parse_st = ST_LEN_FIRST;
			return;
		end
		case (parse_st)
			ST_LEN_FIRST: begin
				buf_left = buf_left - 16'd1;
				nlen = b & botd_pkg::SUB_MASK;
				if (!b[7]) begin
					content_left = 32'(b);
					close_header();
				end else if (nlen == 8'd0 || nlen > 8'(botd_pkg::MAX_LEN_BYTES)) begin
					expect_error(botd_pkg::ERR_LEN_FORM);
				end else if (16'(nlen) > buf_left) begin
					expect_error(botd_pkg::ERR_HDR_CUT);
				end else begin
					len_bytes_left = 3'(nlen);
					content_left = '0;
					parse_st = ST_LEN_MORE;
				end
			end
			ST_LEN_MORE: begin
				content_left = {content_left[23:0], b};
				buf_left = buf_left - 16'd1;
				len_bytes_left = len_bytes_left - 3'd1;
				if (len_bytes_left == 3'd0) close_header();
			end
			ST_CONTENT: begin
				buf_left = buf_left - 16'd1;
				content_left = content_left - 32'd1;
				subid_acc = {subid_acc[24:0], b[6:0]};
				if (!b[7]) begin
					if (!split_done) begin
						top_arc = subid_acc / botd_pkg::ARC_DIV;
						if (top_arc > TOP_ARC_MAX) top_arc = TOP_ARC_MAX;
						expect_result(botd_pkg::KIND_ARC, top_arc, 8'd0,
							botd_pkg::ERR_NONE);
						expect_result(botd_pkg::KIND_ARC,
							subid_acc - botd_pkg::ARC_DIV * top_arc, 8'd1,
							botd_pkg::ERR_NONE);
						arc_count = 8'd2;
						split_done = 1'b1;
					end else if (arc_count >= eff_cap()) begin
						expect_error(botd_pkg::ERR_TOO_MANY);
						return;
					end else begin
						expect_result(botd_pkg::KIND_ARC, subid_acc, arc_count,
							botd_pkg::ERR_NONE);
						arc_count = arc_count + 8'd1;
					end
					subid_acc = '0;
				end
				if (content_left == 32'd0) begin
					expect_result(botd_pkg::KIND_DONE, 32'd0, arc_count,
						botd_pkg::ERR_NONE);
					parse_st = ST_IDLE;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		botd_pkg::res_t want;
		if (!arst_n) begin
			parse_st = ST_IDLE;
			cap_reg = 8'(MAX_ARCS);
			tag_byte = '0;
			len_bytes_left = '0;
			content_left = '0;
			buf_left = '0;
			subid_acc = '0;
			arc_count = '0;
			split_done = 1'b0;
			pending_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected result kind %0d arc %0d pos %0d err %0d",
						rsp.kind, rsp.arc, rsp.arc_position, rsp.error_code));
				end else begin
					want = pending_results.pop_front();
					if (rsp.kind !== want.kind || rsp.arc !== want.arc ||
							rsp.arc_position !== want.arc_position ||
							rsp.error_code !== want.error_code)
						report_mismatch($sformatf(
							"got kind %0d arc %0d pos %0d err %0d, want %0d %0d %0d %0d",
							rsp.kind, rsp.arc, rsp.arc_position, rsp.error_code,
							want.kind, want.arc, want.arc_position, want.error_code));
				end
			end
			if (cfg_we) cap_reg = cfg_wdata;
			if (req.valid && req.ready)
				decode_byte(req.byte_req, req.start_req, req.bytes_left, req.upstream_ok);
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: verif/ber_oid_tlv_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_oid_tlv_decoder_tb
// Drives message bytes into the BER OID TLV decoder: a directed run over the
// header errors, parse restarts, wrapping and unfinished subidentifiers, then
// random OID messages, mostly well formed, under several max_arcs settings
// from 0 to 128. Both channels stall at random except in one quiet phase.
// Results are checked by oid_result_checker.
// ----------------------------------------------------------------------------
module ber_oid_tlv_decoder_tb;

	localparam int MAX_ARCS = 128;
	localparam int PHASE_ITEMS = 42;
	localparam int SETTLE = 20;
	localparam int LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         mismatches;
	int         outstanding;
	int         cycles = 0;
	int         items_sent = 0;
	bit         quiet = 1'b0;
	logic [7:0] body_q[$];
	logic [7:0] frame_q[$];

	botd_req_if req_ch();
	botd_rsp_if rsp_ch();

	ber_oid_tlv_decoder #(.MAX_ARCS(MAX_ARCS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	oid_result_checker #(.MAX_ARCS(MAX_ARCS)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("ber_oid_tlv_decoder_tb failed");
			$finish;
		end
	end

	always @(posedge clk) rsp_ch.ready <= quiet || ($urandom_range(99) >= 6);

	task automatic send_byte(input logic [7:0] b, input logic st, input logic [15:0] left,
			input logic ok);
		while (!quiet && $urandom_range(99) < 6) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.byte_req <= b;
		req_ch.start_req <= st;
		req_ch.bytes_left <= left;
		req_ch.upstream_ok <= ok;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// first byte carries the start; later bytes get junk in the start-only fields
	task automatic send_frame(input logic [15:0] left, input logic ok, input int upto);
		for (int i = 0; i < upto; i++) begin
			if (i == 0) send_byte(frame_q[0], 1'b1, left, ok);
			else send_byte(frame_q[i], 1'b0, 16'($urandom), 1'($urandom));
		end
		items_sent += upto;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cap(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void push_subid(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			body_q.push_back({(i != 0), 7'(v >> (7 * i))});
	endfunction

	function automatic void build_frame(input logic [7:0] tag, input logic [31:0] decl,
			input int lenb);
		frame_q.delete();
		frame_q.push_back(tag);
		if (lenb == 0 && decl < 32'h80) begin
			frame_q.push_back(decl[7:0]);
		end else begin
			if (lenb == 0) lenb = 4;
			frame_q.push_back(botd_pkg::CONT_BIT | 8'(lenb));
			for (int i = lenb - 1; i >= 0; i--) frame_q.push_back(8'(decl >> (8 * i)));
		end
		frame_q = {frame_q, body_q};
	endfunction

	task automatic directed_cases();
		send_byte(botd_pkg::OID_TAG, 1'b0, 16'd9, 1'b1);
		send_byte(botd_pkg::OID_TAG, 1'b1, 16'd9, 1'b0);
		send_byte(botd_pkg::OID_TAG, 1'b1, 16'd0, 1'b1);
		send_byte(botd_pkg::OID_TAG, 1'b1, 16'd1, 1'b1);
		// restart mid-header, then the shortest legal OID
		send_byte(botd_pkg::OID_TAG, 1'b1, 16'd5, 1'b1);
		body_q = {8'h00};
		build_frame(botd_pkg::OID_TAG, 32'd1, 0);
		send_frame(16'hFFFF, 1'b1, 3);
		body_q.delete();
		build_frame(botd_pkg::OID_TAG, 32'd0, 0);
		send_frame(16'd9, 1'b1, 2);
		frame_q[1] = botd_pkg::CONT_BIT;
		send_frame(16'd8, 1'b1, 2);
		frame_q[1] = botd_pkg::CONT_BIT | 8'(botd_pkg::MAX_LEN_BYTES);
		send_frame(16'd3, 1'b1, 2);
		build_frame(botd_pkg::OID_TAG, 32'hFF, 1);
		send_frame(16'd100, 1'b1, 3);
		body_q = {8'h2A};
		build_frame(8'h05, 32'd1, 0);
		send_frame(16'd3, 1'b1, 2);
		// arc0 clamps to 2, wrapping subid, trailing unfinished byte
		body_q = {8'h8F, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h80};
		build_frame(botd_pkg::OID_TAG, 32'd8, 0);
		send_frame(16'(frame_q.size()), 1'b1, frame_q.size());
	endtask

	task automatic random_message();
		int         sel;
		int         size;
		int         upto;
		logic [7:0] tag;
		logic [31:0] decl;
		logic [15:0] left;
		logic       ok;
		body_q.delete();
		repeat ($urandom_range(1, 7))
			push_subid({$urandom, $urandom}, ($urandom_range(9) < 6) ? 1 : $urandom_range(2, 6));
		if ($urandom_range(9) == 0) body_q.push_back(botd_pkg::CONT_BIT | 8'($urandom));
		sel = $urandom_range(99);
		tag = (sel >= 70 && sel < 75) ? 8'($urandom) : botd_pkg::OID_TAG;
		decl = (sel >= 75 && sel < 79) ? 32'd0 : 32'(body_q.size());
		if (decl == 32'd0) body_q.delete();
		build_frame(tag, decl, $urandom_range(0, 4));
		size = frame_q.size();
		left = 16'(size + (($urandom_range(9) == 0) ? $urandom_range(0, 65535 - size)
			: $urandom_range(0, 3)));
		ok = 1'b1;
		upto = size;
		if (sel >= 79 && sel < 84) begin
			left = 16'($urandom_range(0, size - 1));
		end else if (sel >= 84 && sel < 88) begin
			ok = 1'b0;
		end else if (sel >= 88 && sel < 92) begin
			upto = $urandom_range(1, size - 1);
		end else if (sel >= 92 && sel < 96) begin
			frame_q[1] = $urandom_range(1) ? botd_pkg::CONT_BIT : 8'($urandom_range(255, 133));
			upto = 2;
		end
		if (sel >= 96) begin
			repeat ($urandom_range(1, 8)) begin
				send_byte(8'($urandom), $urandom_range(2) == 0, 16'($urandom_range(0, 40)),
					$urandom_range(9) != 0);
				items_sent++;
			end
		end else begin
			send_frame(left, ok, upto);
		end
		if ($urandom_range(19) == 0)
			send_byte(8'($urandom), 1'b0, 16'($urandom), 1'($urandom));
	endtask

	initial begin
		logic [7:0] cap_plan[8];
		int         stop_at;
		cap_plan = '{8'd2, 8'd0, 8'd3, 8'd1, 8'd128, 8'd5, 8'd64, 8'd4};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.byte_req <= '0;
		req_ch.start_req <= 1'b0;
		req_ch.bytes_left <= '0;
		req_ch.upstream_ok <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_cases();
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_cap((p == 7) ? 8'($urandom_range(2, 128)) : cap_plan[p]);
			quiet = (p == 4);
			if (p == 4) begin
				// 127 one-byte subids: 128 arcs, exact-fit buffer
				body_q.delete();
				repeat (127) body_q.push_back(8'($urandom_range(0, 127)));
				build_frame(botd_pkg::OID_TAG, 32'd127, 0);
				send_frame(16'(frame_q.size()), 1'b1, frame_q.size());
			end
			stop_at = items_sent + ((cap_plan[p] < botd_pkg::MIN_CAP) ? 20 : PHASE_ITEMS);
			while (items_sent < stop_at) random_message();
		end
		wait_idle();
		if (mismatches == 0 && outstanding == 0)
			$display("ber_oid_tlv_decoder_tb passed");
		else
			$display("ber_oid_tlv_decoder_tb failed");
		$finish;
	end

endmodule
